// File: rtl/qrt_pkg.sv
// Shared constants, codes and types of the quorum request tracker.
package qrt_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = 2;
    localparam int EXP_W       = 16;
    localparam int QUO_W       = 2;
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = EXP_W;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_EXPIRY = 1'd0;
    localparam t_cfg_idx CFG_QUORUM = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [EXP_W-1:0] EXPIRY_RST = 16'd20;
    localparam logic [QUO_W-1:0] QUORUM_RST = 2'd2;

    // Request operations.
    typedef logic [1:0] t_op;
    localparam t_op OP_ISSUE = 2'd0;
    localparam t_op OP_REPLY = 2'd1;
    localparam t_op OP_TICK  = 2'd2;

    // Result events.
    typedef logic [2:0] t_event;
    localparam t_event EV_ISSUED  = 3'd0;
    localparam t_event EV_FULL    = 3'd1;
    localparam t_event EV_COUNTED = 3'd2;
    localparam t_event EV_DONE    = 3'd3;
    localparam t_event EV_EXPIRED = 3'd4;
    localparam t_event EV_UNKNOWN = 3'd5;

    // The reply count saturates here.
    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

    // One slot of the pending request table.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] issue_time;
        logic [CNT_W-1:0]  count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: rtl/qrt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module qrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/quorum_request_tracker.sv
// Quorum request tracker: table of outstanding replicated requests with reply counting and expiry.
//
// A request is accepted only while the tracker is idle. An issue request is first accepted, then
// the lowest free slot is found and the entry written. A reply or a tick request walks the whole
// pending table through the single read port of the entry memory, one slot per cycle while no
// result is held up by a stalled output; a reply stops early at its matching slot. A result
// that cannot leave because the output is stalled holds the request up. Results wait in an
// output register, so a new request may be accepted while the last result of the previous one
// is still held. A tick expires at most MAX_RESULTS entries and marks its final result with last.
// The slot valid bits are flip-flops cleared by reset, so no clearing pass is needed after reset.
module quorum_request_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [qrt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qrt_pkg::CFG_W-1:0]           i_cfg_data,
    // Request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [qrt_pkg::KIND_W-1:0]          i_request_kind,
    input  logic [qrt_pkg::ID_W-1:0]            i_reply_id,
    input  logic                                i_reply_ok,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_event_res,
    output logic [qrt_pkg::ID_W-1:0]            o_trans_id,
    output logic [qrt_pkg::KIND_W-1:0]          o_kind_out,
    output logic                                o_last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                                   r_state, n_state;
    qrt_pkg::t_op                             r_op, n_op;
    logic [qrt_pkg::KIND_W-1:0]               r_kind, n_kind;
    logic [qrt_pkg::ID_W-1:0]                 r_rid, n_rid;
    logic                                     r_ok, n_ok;
    logic [qrt_pkg::TABLE_DEPTH-1:0]          r_valid, n_valid;
    logic [qrt_pkg::ID_W-1:0]                 r_next_id, n_next_id;
    logic [qrt_pkg::TIME_W-1:0]               r_time, n_time;
    logic [qrt_pkg::EXP_W-1:0]                r_expiry;
    logic [qrt_pkg::QUO_W-1:0]                r_quorum;
    logic [qrt_pkg::IDX_W:0]                  r_rd_idx, n_rd_idx;
    logic                                     r_chk_vld, n_chk_vld;
    logic [qrt_pkg::IDX_W-1:0]                r_chk_idx, n_chk_idx;
    logic [qrt_pkg::RES_W-1:0]                r_found, n_found;
    logic                                     r_hold_vld, n_hold_vld;
    logic [qrt_pkg::ID_W-1:0]                 r_hold_id, n_hold_id;
    logic [qrt_pkg::KIND_W-1:0]               r_hold_kind, n_hold_kind;
    logic                                     r_out_vld, n_out_vld;
    qrt_pkg::t_event                          r_out_ev, n_out_ev;
    logic [qrt_pkg::ID_W-1:0]                 r_out_id, n_out_id;
    logic [qrt_pkg::KIND_W-1:0]               r_out_kind, n_out_kind;
    logic                                     r_out_last, n_out_last;

    logic                                     ram_we;
    logic [qrt_pkg::IDX_W-1:0]                ram_waddr;
    qrt_pkg::t_entry                          ram_wdata;
    logic [qrt_pkg::IDX_W-1:0]                ram_raddr;
    logic [qrt_pkg::ENTRY_W-1:0]              ram_rdata;

    logic                                     out_free;
    logic                                     free_any;
    logic [qrt_pkg::IDX_W-1:0]                free_slot;
    logic [qrt_pkg::ID_W-1:0]                 id_inc;
    logic [qrt_pkg::ID_W-1:0]                 new_id;
    qrt_pkg::t_entry                          chk_e;
    logic                                     chk_live;
    logic [qrt_pkg::TIME_W-1:0]               chk_age;
    logic                                     chk_expired;
    logic                                     chk_match;
    logic [qrt_pkg::CNT_W-1:0]                cnt_new;
    logic                                     cnt_done;
    logic                                     scan_stall;
    logic                                     scan_stop;

    // Entry table: id, kind, issue time and reply count of every slot.
    qrt_ram #(
        .WIDTH (qrt_pkg::ENTRY_W),
        .DEPTH (qrt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The output register can take a result when empty or being emptied.
    assign out_free = !r_out_vld || !i_out_stall;

    // Lowest free slot for an issue.
    always_comb begin
        free_slot = '0;
        for (int i = qrt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = qrt_pkg::IDX_W'(i);
            end
        end
    end
    assign free_any = ~(&r_valid);

    // Next transaction id wraps and never takes the value zero.
    assign id_inc = r_next_id + 1'b1;
    assign new_id = (id_inc == '0) ? qrt_pkg::ID_W'(1) : id_inc;

    // Evaluation of the slot whose entry has just come out of the memory.
    assign chk_e       = qrt_pkg::t_entry'(ram_rdata);
    assign chk_live    = r_chk_vld && r_valid[r_chk_idx];
    assign chk_age     = r_time - chk_e.issue_time;
    assign chk_expired = chk_live && (chk_age > qrt_pkg::TIME_W'(r_expiry));
    assign chk_match   = chk_live && (chk_e.id == r_rid);
    assign cnt_new     = (r_ok && chk_e.count != qrt_pkg::CNT_MAX) ?
                         chk_e.count + 1'b1 : chk_e.count;
    assign cnt_done    = cnt_new >= r_quorum;

    // Sequencer: accepts a request, then issues, or walks the table for a reply or a tick.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_kind      = r_kind;
        n_rid       = r_rid;
        n_ok        = r_ok;
        n_valid     = r_valid;
        n_next_id   = r_next_id;
        n_time      = r_time;
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_hold_vld  = r_hold_vld;
        n_hold_id   = r_hold_id;
        n_hold_kind = r_hold_kind;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out_ev    = r_out_ev;
        n_out_id    = r_out_id;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_chk_idx;
        ram_wdata   = chk_e;
        ram_raddr   = r_chk_idx;
        scan_stall  = 1'b0;
        scan_stop   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_op;
                    n_kind    = i_request_kind;
                    n_rid     = i_reply_id;
                    n_ok      = i_reply_ok;
                    n_rd_idx  = '0;
                    n_chk_vld = 1'b0;
                    n_found   = '0;
                    n_hold_vld = 1'b0;
                    case (i_op)
                        qrt_pkg::OP_ISSUE: begin
                            n_state = S_ISSUE;
                        end
                        qrt_pkg::OP_REPLY: begin
                            n_state = S_SCAN;
                        end
                        qrt_pkg::OP_TICK: begin
                            n_time  = r_time + 1'b1;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ISSUE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_kind = r_kind;
                    n_out_last = 1'b1;
                    if (free_any) begin
                        ram_we                = 1'b1;
                        ram_waddr             = free_slot;
                        ram_wdata.id          = new_id;
                        ram_wdata.kind        = r_kind;
                        ram_wdata.issue_time  = r_time;
                        ram_wdata.count       = '0;
                        n_valid[free_slot]    = 1'b1;
                        n_next_id             = new_id;
                        n_out_ev              = qrt_pkg::EV_ISSUED;
                        n_out_id              = new_id;
                    end else begin
                        n_out_ev = qrt_pkg::EV_FULL;
                        n_out_id = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            S_SCAN: begin
                // Check stage: one expired slot is held back so that the final one can be marked.
                if (r_op == qrt_pkg::OP_TICK && chk_expired) begin
                    if (!r_hold_vld || out_free) begin
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_ev   = qrt_pkg::EV_EXPIRED;
                            n_out_id   = r_hold_id;
                            n_out_kind = r_hold_kind;
                            n_out_last = 1'b0;
                        end
                        n_hold_vld          = 1'b1;
                        n_hold_id           = chk_e.id;
                        n_hold_kind         = chk_e.kind;
                        n_valid[r_chk_idx]  = 1'b0;
                        n_found             = r_found + 1'b1;
                        if (r_found + 1'b1 == qrt_pkg::RES_W'(qrt_pkg::MAX_RESULTS)) begin
                            scan_stop = 1'b1;
                            n_state   = S_FINISH;
                        end
                    end else begin
                        scan_stall = 1'b1;
                    end
                end else if (r_op == qrt_pkg::OP_REPLY && chk_match) begin
                    if (out_free) begin
                        ram_we          = 1'b1;
                        ram_wdata.count = cnt_new;
                        n_out_vld       = 1'b1;
                        n_out_ev        = cnt_done ? qrt_pkg::EV_DONE : qrt_pkg::EV_COUNTED;
                        n_out_id        = r_rid;
                        n_out_kind      = chk_e.kind;
                        n_out_last      = 1'b1;
                        if (cnt_done) begin
                            n_valid[r_chk_idx] = 1'b0;
                        end
                        scan_stop = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        scan_stall = 1'b1;
                    end
                end

                // Read stage: fetch the next slot, or close the walk once all are checked.
                if (!scan_stall && !scan_stop) begin
                    if (r_rd_idx < (qrt_pkg::IDX_W + 1)'(qrt_pkg::TABLE_DEPTH)) begin
                        ram_raddr = r_rd_idx[qrt_pkg::IDX_W-1:0];
                        n_chk_vld = 1'b1;
                        n_chk_idx = r_rd_idx[qrt_pkg::IDX_W-1:0];
                        n_rd_idx  = r_rd_idx + 1'b1;
                    end else begin
                        n_chk_vld = 1'b0;
                        n_state   = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (r_op == qrt_pkg::OP_REPLY) begin
                    // No pending slot carries the reply's id.
                    if (out_free) begin
                        n_out_vld  = 1'b1;
                        n_out_ev   = qrt_pkg::EV_UNKNOWN;
                        n_out_id   = r_rid;
                        n_out_kind = '0;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_hold_vld) begin
                    // Final expired slot of this tick.
                    if (out_free) begin
                        n_out_vld  = 1'b1;
                        n_out_ev   = qrt_pkg::EV_EXPIRED;
                        n_out_id   = r_hold_id;
                        n_out_kind = r_hold_kind;
                        n_out_last = 1'b1;
                        n_hold_vld = 1'b0;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_next_id  <= '0;
            r_time     <= '0;
            r_expiry   <= qrt_pkg::EXPIRY_RST;
            r_quorum   <= qrt_pkg::QUORUM_RST;
            r_chk_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_next_id  <= n_next_id;
            r_time     <= n_time;
            r_chk_vld  <= n_chk_vld;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    qrt_pkg::CFG_EXPIRY: begin
                        r_expiry <= i_cfg_data;
                    end
                    qrt_pkg::CFG_QUORUM: begin
                        r_quorum <= i_cfg_data[qrt_pkg::QUO_W-1:0];
                    end
                    default: begin
                        r_expiry <= r_expiry;
                    end
                endcase
            end
        end
    end

    // Payload registers of the request, the walk and the result.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_kind      <= n_kind;
        r_rid       <= n_rid;
        r_ok        <= n_ok;
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_found     <= n_found;
        r_hold_id   <= n_hold_id;
        r_hold_kind <= n_hold_kind;
        r_out_ev    <= n_out_ev;
        r_out_id    <= n_out_id;
        r_out_kind  <= n_out_kind;
        r_out_last  <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_event_res = r_out_ev;
    assign o_trans_id  = r_out_id;
    assign o_kind_out  = r_out_kind;
    assign o_last      = r_out_last;

endmodule

// File: tb/quorum_request_tracker_tb.sv
// Self-checking testbench for the quorum request tracker: directed cases and random traffic.
module quorum_request_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qrt_pkg::*;

    localparam int  SETTLE_CYCLES  = 40;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  REPORT_LIMIT   = 10;
    localparam t_op OP_IGNORED     = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE,
        KIND_READ,
        KIND_UPDATE,
        KIND_DELETE
    } t_kind;

    typedef struct packed {
        t_event            ev;
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    t_cfg_idx          i_cfg_index    = CFG_EXPIRY;
    logic [CFG_W-1:0]  i_cfg_data     = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    t_op               i_op           = OP_TICK;
    logic [KIND_W-1:0] i_request_kind = '0;
    logic [ID_W-1:0]   i_reply_id     = '0;
    logic              i_reply_ok     = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    t_event            o_event_res;
    logic [ID_W-1:0]   o_trans_id;
    logic [KIND_W-1:0] o_kind_out;
    logic              o_last;

    // Shadow copy of the pending request table and the tracker's settings.
    logic              slot_busy  [TABLE_DEPTH];
    logic [ID_W-1:0]   slot_id    [TABLE_DEPTH];
    logic [KIND_W-1:0] slot_kind  [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_time  [TABLE_DEPTH];
    logic [CNT_W-1:0]  slot_count [TABLE_DEPTH];
    logic [ID_W-1:0]   last_issued_id = '0;
    logic [TIME_W-1:0] tick_count     = '0;
    logic [EXP_W-1:0]  expiry_limit   = EXPIRY_RST;
    logic [QUO_W-1:0]  quorum_needed  = QUORUM_RST;
    t_outcome          upcoming_events [$];

    int gap_max      = 0;
    int stall_pct    = 0;
    int burst_left   = 0;
    int stall_run    = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    quorum_request_tracker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_request_kind (i_request_kind),
        .i_reply_id     (i_reply_id),
        .i_reply_ok     (i_reply_ok),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_trans_id     (o_trans_id),
        .o_kind_out     (o_kind_out),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_outcome result_of(t_event ev, logic [ID_W-1:0] id,
                                           logic [KIND_W-1:0] kind, logic last);
        t_outcome r;
        r.ev   = ev;
        r.id   = id;
        r.kind = kind;
        r.last = last;
        return r;
    endfunction

    // Transaction ids count up, wrap and never take the value zero.
    function automatic logic [ID_W-1:0] following_id(logic [ID_W-1:0] id);
        logic [ID_W-1:0] nid;
        nid = id + 1'b1;
        if (nid == '0) begin
            nid = ID_W'(1);
        end
        return nid;
    endfunction

    // Update the shadow table for one request and queue the results it should cause.
    task automatic track_request(t_op op, logic [KIND_W-1:0] kind,
                                 logic [ID_W-1:0] rid, logic ok);
        int                hit;
        int                expired;
        int                emitted;
        logic [TIME_W-1:0] age;
        logic              doomed [TABLE_DEPTH];
        hit = -1;
        case (op)
            OP_ISSUE: begin
                for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
                    if (!slot_busy[s]) hit = s;
                end
                if (hit < 0) begin
                    upcoming_events.push_back(result_of(EV_FULL, '0, kind, 1'b1));
                end else begin
                    last_issued_id   = following_id(last_issued_id);
                    slot_busy[hit]   = 1'b1;
                    slot_id[hit]     = last_issued_id;
                    slot_kind[hit]   = kind;
                    slot_time[hit]   = tick_count;
                    slot_count[hit]  = '0;
                    upcoming_events.push_back(result_of(EV_ISSUED, last_issued_id, kind, 1'b1));
                end
            end
            OP_REPLY: begin
                // The lowest slot holding the id answers, even when the id is pending twice.
                for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
                    if (slot_busy[s] && slot_id[s] == rid) hit = s;
                end
                if (hit < 0) begin
                    upcoming_events.push_back(result_of(EV_UNKNOWN, rid, '0, 1'b1));
                end else begin
                    if (ok && slot_count[hit] != CNT_MAX) begin
                        slot_count[hit] = slot_count[hit] + 1'b1;
                    end
                    if (slot_count[hit] >= quorum_needed) begin
                        slot_busy[hit] = 1'b0;
                        upcoming_events.push_back(result_of(EV_DONE, rid, slot_kind[hit], 1'b1));
                    end else begin
                        upcoming_events.push_back(
                            result_of(EV_COUNTED, rid, slot_kind[hit], 1'b1));
                    end
                end
            end
            OP_TICK: begin
                // Time moves on first; ages wrap with the tick counter.
                tick_count = tick_count + 1'b1;
                expired = 0;
                for (int s = 0; s < TABLE_DEPTH; s++) begin
                    age = tick_count - slot_time[s];
                    doomed[s] = slot_busy[s] && (age > expiry_limit);
                    if (doomed[s]) expired++;
                end
                emitted = 0;
                for (int s = 0; s < TABLE_DEPTH; s++) begin
                    if (doomed[s]) begin
                        emitted++;
                        slot_busy[s] = 1'b0;
                        upcoming_events.push_back(result_of(EV_EXPIRED, slot_id[s], slot_kind[s],
                                                            emitted == expired));
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Present one request in the sender's burst pattern and wait until it is taken.
    task automatic send_request(t_op op, logic [KIND_W-1:0] kind,
                                logic [ID_W-1:0] rid, logic ok);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        track_request(op, kind, rid, ok);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_request_kind <= kind;
        i_reply_id     <= rid;
        i_reply_ok     <= ok;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Fields that an operation does not use carry random values.
    task automatic issue_request(logic [KIND_W-1:0] kind);
        send_request(OP_ISSUE, kind, ID_W'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    task automatic reply_request(logic [ID_W-1:0] rid, logic ok);
        send_request(OP_REPLY, KIND_W'($urandom_range(3)), rid, ok);
    endtask

    task automatic tick_request();
        send_request(OP_TICK, KIND_W'($urandom_range(3)), ID_W'($urandom_range(65535)),
                     1'($urandom_range(1)));
    endtask

    // Stop sending, wait for every expected result, then let any silent request finish.
    task automatic drain_outstanding();
        i_in_valid <= 1'b0;
        while (upcoming_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers while the tracker is idle; spare data bits above the quorum are noise.
    task automatic apply_settings(logic [EXP_W-1:0] expiry, logic [QUO_W-1:0] quorum);
        logic [31:0] junk;
        junk = $urandom;
        drain_outstanding();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EXPIRY;
        i_cfg_data  <= expiry;
        @(posedge i_clk);
        i_cfg_index <= CFG_QUORUM;
        i_cfg_data  <= {junk[CFG_W-1:QUO_W], quorum};
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        expiry_limit  = expiry;
        quorum_needed = quorum;
    endtask

    function automatic void note_mismatch(string what, t_outcome want, t_outcome seen);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected ev %0d id %0d kind %0d last %0d", $time, what,
                     want.ev, want.id, want.kind, want.last);
            $display("%0t: %s: got      ev %0d id %0d kind %0d last %0d", $time, what,
                     seen.ev, seen.id, seen.kind, seen.last);
        end
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_outcome seen;
        t_outcome want;
        if (o_out_valid && !i_out_stall) begin
            seen = result_of(o_event_res, o_trans_id, o_kind_out, o_last);
            if (upcoming_events.size() == 0) begin
                note_mismatch("result with nothing pending", '0, seen);
            end else begin
                want = upcoming_events.pop_front();
                if (seen.ev !== want.ev || seen.id !== want.id ||
                    seen.kind !== want.kind || seen.last !== want.last) begin
                    note_mismatch("result differs", want, seen);
                end
            end
        end
    end

    // The receiver stalls in runs of random length at the current stall rate.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_run   <= $urandom_range(8, 1);
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("quorum_request_tracker_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Issue into every slot, a full table, replies short of and at the quorum, unknown ids.
    task automatic test_issue_reply();
        gap_max   = 3;
        stall_pct = 40;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            issue_request(n[KIND_W-1:0]);
        end
        issue_request(KIND_DELETE);
        send_request(OP_IGNORED, KIND_READ, '1, 1'b1);
        // A good reply, a failed one that leaves the count unchanged, then the reply that completes.
        reply_request(slot_id[0], 1'b1);
        reply_request(slot_id[0], 1'b0);
        reply_request(slot_id[0], 1'b1);
        reply_request('1, 1'b1);
        reply_request('0, 1'b0);
        // The freed lowest slot is reused; a tick this early expires nothing.
        issue_request(KIND_UPDATE);
        tick_request();
    endtask

    // A quorum of zero completes on any reply; an expiry of zero clears the table on one tick.
    task automatic test_quorum_zero_expiry();
        apply_settings('0, '0);
        gap_max   = 1;
        stall_pct = 60;
        reply_request(slot_id[1], 1'b0);
        tick_request();
        tick_request();
    endtask

    // One phase of random requests under fixed settings and idling.
    task automatic random_phase(int items, logic [EXP_W-1:0] expiry, logic [QUO_W-1:0] quorum,
                                int stall, int gaps);
        int              sent;
        int              pick;
        int              slot;
        logic [ID_W-1:0] rid;
        apply_settings(expiry, quorum);
        stall_pct = stall;
        gap_max   = gaps;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_request(OP_IGNORED, KIND_W'($urandom_range(3)),
                             ID_W'($urandom_range(65535)), 1'($urandom_range(1)));
            end else begin
                sent++;
                if (pick < 38) begin
                    issue_request(KIND_W'($urandom_range(3)));
                end else if (pick < 72) begin
                    // Answer a pending request where there is one.
                    slot = $urandom_range(TABLE_DEPTH - 1);
                    for (int k = 0; k < TABLE_DEPTH && !slot_busy[slot]; k++) begin
                        slot = (slot + 1) % TABLE_DEPTH;
                    end
                    if (slot_busy[slot]) begin
                        reply_request(slot_id[slot], $urandom_range(9) < 7);
                    end else begin
                        reply_request(ID_W'($urandom_range(65535)), 1'($urandom_range(1)));
                    end
                end else if (pick < 82) begin
                    // Stale ids near the counter, or anything at all.
                    if ($urandom_range(1) == 1) begin
                        rid = last_issued_id - ID_W'($urandom_range(20));
                    end else begin
                        rid = ID_W'($urandom_range(65535));
                    end
                    reply_request(rid, 1'($urandom_range(1)));
                end else begin
                    tick_request();
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(60, EXPIRY_RST, QUORUM_RST, 30, 4);
        random_phase(60, 16'd1, 2'd3, 0, 0);
        random_phase(60, '1, 2'd1, 70, 8);
        random_phase(60, 16'd5, 2'd2, 20, 2);
        random_phase(60, 16'd2, 2'd3, 50, 0);
        random_phase(60, EXP_W'($urandom_range(16, 1)), QUO_W'($urandom_range(3, 1)), 10, 6);
    endtask

    initial begin
        foreach (slot_busy[s]) begin
            slot_busy[s]  = 1'b0;
            slot_id[s]    = '0;
            slot_kind[s]  = '0;
            slot_time[s]  = '0;
            slot_count[s] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_issue_reply();
        test_quorum_zero_expiry();
        test_random_traffic();
        drain_outstanding();
        if (mismatches == 0) begin
            $display("quorum_request_tracker_tb OK");
        end else begin
            $display("quorum_request_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule
